[hdl/sprite_texel_fetch_decode_assert.svh]
// assertion macros for the sprite texel fetch and decode block
`ifndef SPRITE_TEXEL_FETCH_DECODE_ASSERT_SVH
`define SPRITE_TEXEL_FETCH_DECODE_ASSERT_SVH

`ifndef ASSERT_OFF
`define STF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define STF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define STF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/stf_pkg.sv]
`default_nettype none

package stf_pkg;

	localparam int MEM_ADDR_BITS = 18;
	localparam int MEM_WORDS = 1 << MEM_ADDR_BITS;
	localparam int X_W = 20;
	localparam int BASE_W = 18;
	localparam int CALC_W = (MEM_ADDR_BITS > X_W) ? MEM_ADDR_BITS : X_W;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_END_CODE_DISABLE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SKIP_PIXEL_DISABLE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEXTURE_BASE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_BANK_OR = 3'd4;

	localparam logic [2:0] MODE_BANK4 = 3'd0;
	localparam logic [2:0] MODE_TABLE4 = 3'd1;
	localparam logic [2:0] MODE_BANK6 = 3'd2;
	localparam logic [2:0] MODE_BANK7 = 3'd3;
	localparam logic [2:0] MODE_BANK8 = 3'd4;
	localparam logic [2:0] MODE_RGB = 3'd5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		KIND_FETCH = 2'd0,
		KIND_MEM_WR = 2'd1,
		KIND_TABLE_WR = 2'd2,
		KIND_CNT_LD = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0] color_mode;
		logic end_code_disable;
		logic skip_pixel_disable;
		logic [BASE_W-1:0] texture_base;
		logic [15:0] color_bank_or;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic [MEM_ADDR_BITS-1:0] addr;
		logic [1:0] sel;
		logic [3:0] table_index;
		logic [15:0] write_data;
		logic [7:0] counter_value;
	} op_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic transparent;
		logic end_code_hit;
		logic [7:0] end_code_count;
	} res_t;

endpackage

`default_nettype wire

[hdl/stf_in_if.sv]
`default_nettype none

interface stf_in_if;
	import stf_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [X_W-1:0] texel_x;
	logic [17:0] memory_address;
	logic [3:0] table_index;
	logic [15:0] write_data;
	logic [7:0] counter_value;

	modport source (
		output valid, kind, texel_x, memory_address, table_index, write_data, counter_value,
		input ready
	);
	modport sink (
		input valid, kind, texel_x, memory_address, table_index, write_data, counter_value,
		output ready
	);
endinterface

`default_nettype wire

[hdl/stf_out_if.sv]
`default_nettype none

interface stf_out_if;
	logic valid;
	logic ready;
	logic [15:0] pixel;
	logic transparent;
	logic end_code_hit;
	logic [7:0] end_code_count;

	modport source (
		output valid, pixel, transparent, end_code_hit, end_code_count,
		input ready
	);
	modport sink (
		input valid, pixel, transparent, end_code_hit, end_code_count,
		output ready
	);
endinterface

`default_nettype wire

[hdl/stf_front.sv]
`default_nettype none

module stf_front (
	stf_in_if.sink items,
	input stf_pkg::cfg_t cfg,
	input logic room,
	output logic push,
	output stf_pkg::op_t push_op
);
	import stf_pkg::*;

	logic [CALC_W-1:0] x_w;
	logic [CALC_W-1:0] base_w;
	logic [CALC_W-1:0] offset;
	logic [CALC_W-1:0] sum;
	logic [CALC_W-1:0] maddr_w;
	logic reserved;
	logic [1:0] sel;

	assign items.ready = room;
	assign push = items.valid && room;

	assign x_w = CALC_W'(items.texel_x);
	assign base_w = CALC_W'(cfg.texture_base);
	assign maddr_w = CALC_W'(items.memory_address);

	// texel position to word offset and in-word select
	always_comb begin
		reserved = 1'b0;
		offset = x_w;
		sel = 2'd0;
		if (cfg.color_mode inside {MODE_BANK4, MODE_TABLE4}) begin
			offset = x_w >> 2;
			sel = items.texel_x[1:0];
		end else if (cfg.color_mode inside {[MODE_BANK6:MODE_BANK8]}) begin
			offset = x_w >> 1;
			sel = {1'b0, items.texel_x[0]};
		end else if (cfg.color_mode != MODE_RGB) begin
			reserved = 1'b1;
		end
	end

	assign sum = base_w + offset;

	always_comb begin
		push_op.kind = kind_t'(items.kind);
		push_op.sel = sel;
		push_op.table_index = items.table_index;
		push_op.write_data = items.write_data;
		push_op.counter_value = items.counter_value;
		if (kind_t'(items.kind) == KIND_MEM_WR) begin
			push_op.addr = maddr_w[MEM_ADDR_BITS-1:0];
		end else if (reserved) begin
			push_op.addr = '0;
		end else begin
			push_op.addr = sum[MEM_ADDR_BITS-1:0];
		end
	end
endmodule

`default_nettype wire

[hdl/stf_queue.sv]
`default_nettype none

module stf_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input stf_pkg::op_t push_op,
	output logic room,
	output logic pop_valid,
	output stf_pkg::op_t pop_op,
	input logic pop
);
	import stf_pkg::*;

	op_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign room = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

`default_nettype wire

[hdl/stf_back.sv]
`default_nettype none

module stf_back (
	input logic clk,
	input logic arst_n,
	input stf_pkg::cfg_t cfg,
	input logic pop_valid,
	input stf_pkg::op_t pop_op,
	output logic pop,
	stf_out_if.source results
);
	import stf_pkg::*;

	logic [15:0] mem_q [MEM_WORDS];
	logic [15:0] table_q [16];
	logic [7:0] cnt_q;

	logic v_s1;
	op_t op_s1;
	logic [15:0] rdata_s1;

	logic out_v_q;
	res_t res_q;

	logic adv_out;
	logic [3:0] nib;
	logic [7:0] byt;
	logic [15:0] value;
	logic is_end;
	logic is_skip;
	logic [7:0] cnt_next;
	res_t res;

	assign adv_out = !out_v_q || results.ready;
	assign pop = pop_valid && (!v_s1 || adv_out);

	// video memory: write and read at issue
	always_ff @(posedge clk) begin
		if (pop && pop_op.kind == KIND_MEM_WR) begin
			mem_q[pop_op.addr] <= pop_op.write_data;
		end
		if (pop) begin
			rdata_s1 <= mem_q[pop_op.addr];
			op_s1 <= pop_op;
		end
	end

	always_comb begin
		case (op_s1.sel)
			2'd0: nib = rdata_s1[15:12];
			2'd1: nib = rdata_s1[11:8];
			2'd2: nib = rdata_s1[7:4];
			default: nib = rdata_s1[3:0];
		endcase
		byt = op_s1.sel[0] ? rdata_s1[7:0] : rdata_s1[15:8];
	end

	// texel decode
	always_comb begin
		if (cfg.color_mode inside {MODE_BANK4, MODE_TABLE4}) begin
			is_end = nib == 4'hF;
			is_skip = nib == 4'h0;
			if (cfg.color_mode == MODE_BANK4) begin
				value = {12'h000, nib} | cfg.color_bank_or;
			end else begin
				value = table_q[nib];
			end
		end else if (cfg.color_mode inside {[MODE_BANK6:MODE_BANK8]}) begin
			is_end = byt == 8'hFF;
			is_skip = byt == 8'h00;
			case (cfg.color_mode)
				MODE_BANK6: value = {10'h000, byt[5:0]} | cfg.color_bank_or;
				MODE_BANK7: value = {9'h000, byt[6:0]} | cfg.color_bank_or;
				default: value = {8'h00, byt} | cfg.color_bank_or;
			endcase
		end else begin
			is_end = rdata_s1[15:14] == 2'b01;
			is_skip = rdata_s1[15:14] == 2'b00;
			value = rdata_s1;
		end
	end

	always_comb begin
		res.pixel = 16'h0000;
		res.transparent = 1'b0;
		res.end_code_hit = 1'b0;
		cnt_next = cnt_q;
		case (op_s1.kind)
			KIND_FETCH: begin
				if (!cfg.end_code_disable && is_end) begin
					res.transparent = 1'b1;
					res.end_code_hit = 1'b1;
					cnt_next = cnt_q - 8'd1;
				end else if (!cfg.skip_pixel_disable && is_skip) begin
					res.pixel = 16'hFFFF;
					res.transparent = 1'b1;
				end else begin
					res.pixel = value;
				end
			end
			KIND_CNT_LD: cnt_next = op_s1.counter_value;
			default: cnt_next = cnt_q;
		endcase
		res.end_code_count = cnt_next;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv_out && op_s1.kind == KIND_TABLE_WR) begin
			table_q[op_s1.table_index] <= op_s1.write_data;
		end
		if (v_s1 && adv_out) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_v_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (adv_out) begin
				v_s1 <= 1'b0;
			end
			if (adv_out) begin
				out_v_q <= v_s1;
			end
			if (v_s1 && adv_out) begin
				cnt_q <= cnt_next;
			end
		end
	end

	assign results.valid = out_v_q;
	assign results.pixel = res_q.pixel;
	assign results.transparent = res_q.transparent;
	assign results.end_code_hit = res_q.end_code_hit;
	assign results.end_code_count = res_q.end_code_count;
endmodule

`default_nettype wire

[hdl/sprite_texel_fetch_decode.sv]
// an input transfer passes through the queue, the memory read stage and the output register to result valid
// throughput: one item per cycle while results are taken; the single video memory read at issue sets it
// a stalled output fills the two-entry queue before input ready drops
// reset clears configuration, end-code counter, queue and pipeline valids
// video memory and colour table hold no reset and have no clearing pass
`default_nettype none

`include "sprite_texel_fetch_decode_assert.svh"

module sprite_texel_fetch_decode (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [stf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [stf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	stf_in_if.sink items,
	stf_out_if.source results
);
	import stf_pkg::*;

	cfg_t cfg_q;
	logic room;
	logic push;
	op_t push_op;
	logic q_valid;
	op_t q_op;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOR_MODE: cfg_q.color_mode <= cfg_wdata[2:0];
				REG_END_CODE_DISABLE: cfg_q.end_code_disable <= cfg_wdata[0];
				REG_SKIP_PIXEL_DISABLE: cfg_q.skip_pixel_disable <= cfg_wdata[0];
				REG_TEXTURE_BASE: cfg_q.texture_base <= cfg_wdata[BASE_W-1:0];
				REG_COLOR_BANK_OR: cfg_q.color_bank_or <= cfg_wdata[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	stf_front u_front (
		.items(items),
		.cfg(cfg_q),
		.room(room),
		.push(push),
		.push_op(push_op)
	);

	stf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_op(push_op),
		.room(room),
		.pop_valid(q_valid),
		.pop_op(q_op),
		.pop(q_pop)
	);

	stf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop_valid(q_valid),
		.pop_op(q_op),
		.pop(q_pop),
		.results(results)
	);

	`STF_ASSERT_IMP(a_pop_needs_entry, clk, arst_n, q_pop, q_valid)
	`STF_ASSERT_IMP(a_full_not_empty, clk, arst_n, !items.ready, q_valid)
	`STF_ASSERT_NXT(a_entry_kept, clk, arst_n, q_valid && !q_pop, q_valid)
	`STF_ASSERT_IMP(a_end_code_blank, clk, arst_n, results.valid && results.end_code_hit,
		results.transparent && results.pixel == 16'h0000)
endmodule

`default_nettype wire

[sim/stf_result_checker.sv]
`timescale 1ns / 100ps

module stf_result_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [stf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [stf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	stf_in_if items,
	stf_out_if results,
	output int fail_count,
	output int pending
);
	import stf_pkg::*;

	cfg_t settings;
	logic [15:0] vram [MEM_WORDS];
	logic [15:0] clut [16];
	logic [7:0] end_count;
	res_t pixel_q [$];

	function automatic res_t decode_item(kind_t kind, logic [X_W-1:0] x, logic [17:0] maddr,
			logic [3:0] tidx, logic [15:0] wdata, logic [7:0] cval);
		logic [17:0] addr;
		logic [15:0] word;
		logic [15:0] value;
		logic [3:0] nib;
		logic [7:0] texel_byte;
		logic is_end;
		logic is_skip;
		res_t r;
		r = '0;
		case (kind)
		KIND_MEM_WR: vram[maddr] = wdata;
		KIND_TABLE_WR: clut[tidx] = wdata;
		KIND_CNT_LD: end_count = cval;
		default: begin
			if (settings.color_mode <= MODE_TABLE4) begin
				addr = settings.texture_base + x[19:2];
				word = vram[addr];
				nib = 4'(word >> {~x[1:0], 2'b00});
				is_end = (nib == 4'hF);
				is_skip = (nib == 4'h0);
				if (settings.color_mode == MODE_BANK4)
					value = {12'h000, nib} | settings.color_bank_or;
				else
					value = clut[nib];
			end else if (settings.color_mode <= MODE_BANK8) begin
				addr = settings.texture_base + x[18:1];
				word = vram[addr];
				texel_byte = x[0] ? word[7:0] : word[15:8];
				is_end = (texel_byte == 8'hFF);
				is_skip = (texel_byte == 8'h00);
				if (settings.color_mode == MODE_BANK6)
					value = {8'h00, texel_byte & 8'h3F} | settings.color_bank_or;
				else if (settings.color_mode == MODE_BANK7)
					value = {8'h00, texel_byte & 8'h7F} | settings.color_bank_or;
				else
					value = {8'h00, texel_byte} | settings.color_bank_or;
			end else begin
				// reserved modes always read word 0
				addr = (settings.color_mode == MODE_RGB) ? settings.texture_base + x[17:0] : '0;
				word = vram[addr];
				is_end = (word[15:14] == 2'b01);
				is_skip = (word[15:14] == 2'b00);
				value = word;
			end
			if (!settings.end_code_disable && is_end) begin
				end_count = end_count - 8'd1;
				r.transparent = 1'b1;
				r.end_code_hit = 1'b1;
			end else if (!settings.skip_pixel_disable && is_skip) begin
				r.pixel = 16'hFFFF;
				r.transparent = 1'b1;
			end else begin
				r.pixel = value;
			end
		end
		endcase
		r.end_code_count = end_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		res_t got;
		if (!arst_n) begin
			settings = '0;
			end_count = '0;
			pixel_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (results.valid && results.ready) begin
				got = {results.pixel, results.transparent, results.end_code_hit,
					results.end_code_count};
				if (pixel_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result pixel %h transparent %b hit %b count %h",
							$realtime, got.pixel, got.transparent, got.end_code_hit,
							got.end_code_count);
				end else begin
					want = pixel_q.pop_front();
					if (got.pixel !== want.pixel || got.transparent !== want.transparent ||
							got.end_code_hit !== want.end_code_hit ||
							got.end_code_count !== want.end_code_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: expected pixel %h transparent %b hit %b count %h, got %h %b %b %h",
								$realtime, want.pixel, want.transparent, want.end_code_hit,
								want.end_code_count, got.pixel, got.transparent,
								got.end_code_hit, got.end_code_count);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_COLOR_MODE: settings.color_mode = cfg_wdata[2:0];
				REG_END_CODE_DISABLE: settings.end_code_disable = cfg_wdata[0];
				REG_SKIP_PIXEL_DISABLE: settings.skip_pixel_disable = cfg_wdata[0];
				REG_TEXTURE_BASE: settings.texture_base = cfg_wdata[BASE_W-1:0];
				REG_COLOR_BANK_OR: settings.color_bank_or = cfg_wdata[15:0];
				default: ;
				endcase
			end
			if (items.valid && items.ready)
				pixel_q.push_back(decode_item(kind_t'(items.kind), items.texel_x,
					items.memory_address, items.table_index, items.write_data,
					items.counter_value));
			pending = pixel_q.size();
		end
	end

endmodule

[sim/sprite_texel_fetch_decode_test.sv]
`timescale 1ns / 100ps

module sprite_texel_fetch_decode_test;
	import stf_pkg::*;

	localparam logic [2:0] MODE_RESERVED6 = 3'd6;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASES = 24;
	localparam int PHASE_ITEMS = 44;
	localparam int HOLD_PHASE = 3;
	localparam int PAUSE_PHASE = 6;

	typedef struct {
		kind_t kind;
		logic [X_W-1:0] x;
		logic [17:0] addr;
		logic [3:0] index;
		logic [15:0] data;
		logic [7:0] count;
	} texel_req_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int quiet_cycles;
	bit hold_off_request;
	bit tx_steady;
	bit rx_steady;
	bit tx_no_gaps;
	bit mem_written [MEM_WORDS];
	logic [17:0] written_list [$];
	logic [2:0] cur_mode;
	logic [17:0] cur_base;

	stf_in_if item_ch();
	stf_out_if result_ch();

	sprite_texel_fetch_decode DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.items(item_ch),
		.results(result_ch)
	);

	stf_result_checker texel_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.items(item_ch),
		.results(result_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("sprite_texel_fetch_decode_test failed");
		$finish;
	end

	function automatic texel_req_t random_req(kind_t kind);
		texel_req_t req;
		req.kind = kind;
		req.x = X_W'($urandom);
		req.addr = 18'($urandom);
		req.index = 4'($urandom);
		req.data = 16'($urandom);
		req.count = 8'($urandom);
		return req;
	endfunction

	// words rich in zero and all-ones nibbles and bytes
	function automatic logic [15:0] texel_word();
		logic [15:0] w;
		int i;
		w = 16'($urandom);
		case ($urandom_range(0, 2))
		1: begin
			for (i = 0; i < 4; i++)
				case ($urandom_range(0, 2))
				0: w[i*4 +: 4] = 4'h0;
				1: w[i*4 +: 4] = 4'hF;
				default: ;
				endcase
		end
		2: begin
			for (i = 0; i < 2; i++)
				case ($urandom_range(0, 2))
				0: w[i*8 +: 8] = 8'h00;
				1: w[i*8 +: 8] = 8'hFF;
				default: ;
				endcase
		end
		default: ;
		endcase
		return w;
	endfunction

	// texel coordinate that lands on a word already written
	function automatic logic [X_W-1:0] legal_x();
		logic [17:0] target;
		logic [17:0] off;
		logic [X_W-1:0] x;
		int n;
		x = X_W'($urandom);
		if (cur_mode > MODE_RGB)
			return x;
		n = written_list.size();
		if (n > 16 && $urandom_range(0, 1))
			target = written_list[n - 1 - $urandom_range(0, 15)];
		else
			target = written_list[$urandom_range(0, n - 1)];
		off = target - cur_base;
		if (cur_mode <= MODE_TABLE4)
			x[19:2] = off;
		else if (cur_mode <= MODE_BANK8)
			x[18:1] = off;
		else
			x[17:0] = off;
		return x;
	endfunction

	task automatic send_item(texel_req_t req);
		int gap;
		if ($urandom_range(0, 19) == 0)
			tx_steady = !tx_steady;
		gap = (tx_steady || tx_no_gaps) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= req.kind;
		item_ch.texel_x <= req.x;
		item_ch.memory_address <= req.addr;
		item_ch.table_index <= req.index;
		item_ch.write_data <= req.data;
		item_ch.counter_value <= req.count;
		if (req.kind == KIND_MEM_WR && !mem_written[req.addr]) begin
			mem_written[req.addr] = 1'b1;
			written_list.push_back(req.addr);
		end
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic fetch(logic [X_W-1:0] x);
		texel_req_t req;
		req = random_req(KIND_FETCH);
		req.x = x;
		send_item(req);
	endtask

	task automatic write_word(logic [17:0] addr, logic [15:0] data);
		texel_req_t req;
		req = random_req(KIND_MEM_WR);
		req.addr = addr;
		req.data = data;
		send_item(req);
	endtask

	task automatic write_entry(logic [3:0] index, logic [15:0] data);
		texel_req_t req;
		req = random_req(KIND_TABLE_WR);
		req.index = index;
		req.data = data;
		send_item(req);
	endtask

	task automatic load_counter(logic [7:0] value);
		texel_req_t req;
		req = random_req(KIND_CNT_LD);
		req.count = value;
		send_item(req);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// unused upper bits of the write data carry junk
	task automatic load_settings(logic [2:0] mode, logic ecd, logic spd, logic [17:0] base,
			logic [15:0] bank);
		logic [CFG_DATA_W-1:0] junk;
		wait_drained();
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_COLOR_MODE, {junk[17:3], mode});
		write_reg(REG_END_CODE_DISABLE, {junk[17:1], ecd});
		write_reg(REG_SKIP_PIXEL_DISABLE, {junk[16:0], spd});
		write_reg(REG_TEXTURE_BASE, base);
		write_reg(REG_COLOR_BANK_OR, {junk[1:0], bank});
		cfg_we <= 1'b0;
		cur_mode = mode;
		cur_base = base;
		@(negedge clk);
	endtask

	initial begin : result_sink
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				gap = HOLD_OFF_CYCLES;
			end else begin
				if ($urandom_range(0, 19) == 0)
					rx_steady = !rx_steady;
				gap = rx_steady ? 0 : $urandom_range(0, 13);
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [2:0] mode;
		logic [17:0] base;
		logic [15:0] bank;
		logic ecd;
		logic spd;
		int p;
		int i;
		int pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COLOR_MODE;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_FETCH;
		item_ch.texel_x = '0;
		item_ch.memory_address = '0;
		item_ch.table_index = '0;
		item_ch.write_data = '0;
		item_ch.counter_value = '0;
		cur_mode = MODE_BANK4;
		cur_base = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: 4-bit bank mode, nibbles high first
		write_word(18'h00000, 16'hF0A5);
		fetch(20'h00000);
		fetch(20'h00001);
		fetch(20'h00002);
		fetch(20'h00003);
		write_word(18'h3FFFF, 16'h00FF);
		fetch(20'hFFFFC);
		fetch(20'hFFFFF);
		write_entry(4'h0, 16'h0000);
		write_entry(4'hF, 16'hFFFF);
		load_counter(8'hFF);
		load_counter(8'h00);

		// end codes and skips disabled, address wrap through bit 19
		load_settings(MODE_BANK8, 1'b1, 1'b1, 18'h00000, 16'hC000);
		fetch(20'h00000);
		fetch(20'h00001);
		fetch(20'hFFFFF);

		load_settings(MODE_RGB, 1'b0, 1'b0, 18'h3FFFF, 16'h0000);
		write_word(18'h00001, 16'h4123);
		write_word(18'h00002, 16'h3FFF);
		fetch(20'h00002);
		fetch(20'h00003);
		fetch(20'h00001);

		load_settings(MODE_RESERVED6, 1'b0, 1'b0, 18'h12345, 16'hFFFF);
		fetch(20'hFFFFF);

		for (i = 0; i < 16; i++)
			write_entry(4'(i), 16'($urandom));

		for (p = 0; p < PHASES; p++) begin
			mode = (p < 8) ? 3'(p) : 3'($urandom);
			ecd = (p < 8) ? p[0] : 1'($urandom);
			spd = (p < 8) ? p[1] : 1'($urandom);
			case ($urandom_range(0, 3))
			0: base = 18'h00000;
			1: base = 18'h3FFFF;
			default: base = 18'($urandom);
			endcase
			case ($urandom_range(0, 3))
			0: bank = 16'h0000;
			1: bank = 16'hFFFF;
			2: bank = 16'($urandom) & 16'hFF00;
			default: bank = 16'($urandom);
			endcase
			load_settings(mode, ecd, spd, base, bank);
			if (p == HOLD_PHASE) begin
				hold_off_request = 1'b1;
				tx_no_gaps = 1'b1;
			end
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2)
					wait_drained();
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					fetch(legal_x());
				end else if (pick < 85) begin
					case ($urandom_range(0, 4))
					0, 1: write_word(cur_base + 18'($urandom_range(0, 15)), texel_word());
					2: write_word(18'($urandom), texel_word());
					3: write_word(18'h00000, texel_word());
					default: write_word(18'h3FFFF, texel_word());
					endcase
				end else if (pick < 93) begin
					write_entry(4'($urandom), 16'($urandom));
				end else begin
					load_counter(8'($urandom));
				end
			end
			tx_no_gaps = 1'b0;
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("sprite_texel_fetch_decode_test passed");
		else
			$display("sprite_texel_fetch_decode_test failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/stf_pkg.sv
hdl/stf_in_if.sv
hdl/stf_out_if.sv
hdl/stf_front.sv
hdl/stf_queue.sv
hdl/stf_back.sv
hdl/sprite_texel_fetch_decode.sv
sim/stf_result_checker.sv
sim/sprite_texel_fetch_decode_test.sv
